@@ rtl/shamh_pkg.sv @@
// Package with the SHA-256 constants, types and round functions.
package shamh_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] vars_t;

  localparam vars_t IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  function automatic word_t ror(input word_t x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    round_k = k;
  endfunction

endpackage

@@ rtl/shamh_in_if.sv @@
// Input channel: one message byte with its flags per word.
interface shamh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;
  modport source (output valid, data_byte, byte_valid, last, input ready);
  modport sink (input valid, data_byte, byte_valid, last, output ready);
endinterface

@@ rtl/shamh_out_if.sv @@
// Output channel: the eight digest words of one message per word.
interface shamh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;
  logic [31:0] digest_word4;
  logic [31:0] digest_word5;
  logic [31:0] digest_word6;
  logic [31:0] digest_word7;
  modport source (output valid, digest_word0, digest_word1, digest_word2, digest_word3,
                  digest_word4, digest_word5, digest_word6, digest_word7, input ready);
  modport sink (input valid, digest_word0, digest_word1, digest_word2, digest_word3,
                digest_word4, digest_word5, digest_word6, digest_word7, output ready);
endinterface

@@ rtl/shamh_round.sv @@
// Shared SHA-256 round unit with the message schedule step.
module shamh_round (
  input  shamh_pkg::vars_t     vars_i,
  input  shamh_pkg::word_t     w0_i,
  input  shamh_pkg::word_t     w1_i,
  input  shamh_pkg::word_t     w9_i,
  input  shamh_pkg::word_t     w14_i,
  input  logic [5:0]           round_i,
  output shamh_pkg::vars_t     vars_o,
  output shamh_pkg::word_t     w_new_o
);
  import shamh_pkg::*;

  word_t big1, choose, t1, big0, major, sg0, sg1;

  always_comb begin
    big1   = ror(vars_i[4], 6) ^ ror(vars_i[4], 11) ^ ror(vars_i[4], 25);
    choose = (vars_i[4] & vars_i[5]) ^ (~vars_i[4] & vars_i[6]);
    t1     = vars_i[7] + big1 + choose + round_k(round_i) + w0_i;
    big0   = ror(vars_i[0], 2) ^ ror(vars_i[0], 13) ^ ror(vars_i[0], 22);
    major  = (vars_i[0] & vars_i[1]) ^ (vars_i[0] & vars_i[2]) ^ (vars_i[1] & vars_i[2]);
    vars_o[7] = vars_i[6];
    vars_o[6] = vars_i[5];
    vars_o[5] = vars_i[4];
    vars_o[4] = vars_i[3] + t1;
    vars_o[3] = vars_i[2];
    vars_o[2] = vars_i[1];
    vars_o[1] = vars_i[0];
    vars_o[0] = t1 + big0 + major;
    sg0 = ror(w1_i, 7) ^ ror(w1_i, 18) ^ (w1_i >> 3);
    sg1 = ror(w14_i, 17) ^ ror(w14_i, 19) ^ (w14_i >> 10);
    w_new_o = w0_i + sg0 + w9_i + sg1;
  end

endmodule

@@ rtl/sha256_message_hasher_core.sv @@
// Top level: byte packing, padding sequencer and digest output of the SHA-256 hasher.
// Usage:
// - in_i takes one word per handshake: a message byte, its byte_valid flag and last.
//   last marks the final word of a message; a final word with byte_valid low ends
//   the message without adding a byte, so an empty message is allowed.
// - out_o presents the eight digest words, word0 most significant, one result per message.
// Timing:
// - A byte that does not complete a 64-byte block is taken with in_i staying ready.
// - The byte that completes a block starts one compression: the rounds on the
//   single round unit, then a fold into the chain, with in_i idle throughout.
// - A final word adds a padding step and one or two compressions (two when 56 or
//   more bytes of the last block are used) before the result.
// - No bytes are taken while a compression runs: in_i is ready only when idle.
// Reset puts the chain words at the initial hash values and the byte count at zero.
// A result waits in the output register while out_o is stalled; further bytes are
// still taken, and the next digest waits in the fold step until the register is free.
module sha256_message_hasher_core (
  input logic        clk_i,
  input logic        rst_ni,
  shamh_in_if.sink   in_i,
  shamh_out_if.source out_o
);
  import shamh_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_PAD, ST_RUN, ST_FOLD} state_e;
  typedef enum logic [1:0] {PH_MSG, PH_SPILL, PH_FINAL} phase_e;

  state_e        state_q;
  phase_e        phase_q;
  logic          pend_last_q;
  logic [5:0]    round_q;
  logic [60:0]   count_q;
  vars_t         chain_q, vars_q, vars_d, digest_q;
  word_t [15:0]  w_q, padded;
  word_t         w_new;
  logic          out_valid_q;
  logic [5:0]    pos;
  logic [63:0]   bit_len;
  logic          accept;
  logic          digest_load;

  shamh_round u_round (
    .vars_i (vars_q),
    .w0_i   (w_q[0]),
    .w1_i   (w_q[1]),
    .w9_i   (w_q[9]),
    .w14_i  (w_q[14]),
    .round_i(round_q),
    .vars_o (vars_d),
    .w_new_o(w_new)
  );

  assign pos     = count_q[5:0];
  assign bit_len = {count_q, 3'b000};
  assign accept  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign digest_load = (state_q == ST_FOLD) && (phase_q == PH_FINAL) &&
                       (!out_valid_q || out_o.ready);

  // Padded block: bytes before the write position are kept, then 0x80, then zeros.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 4; j++) begin
        if ({i[3:0], j[1:0]} < pos) begin
          padded[i][8*(3-j) +: 8] = w_q[i][8*(3-j) +: 8];
        end else if ({i[3:0], j[1:0]} == pos) begin
          padded[i][8*(3-j) +: 8] = PAD_BYTE;
        end else begin
          padded[i][8*(3-j) +: 8] = 8'h00;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_MSG;
      pend_last_q <= 1'b0;
      round_q     <= '0;
      count_q     <= '0;
      chain_q     <= IV;
      out_valid_q <= 1'b0;
    end else begin
      if (digest_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            pend_last_q <= in_i.last;
            if (in_i.byte_valid) begin
              w_q[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= in_i.data_byte;
              count_q <= count_q + 61'd1;
              if (pos == 6'd63) begin
                phase_q <= PH_MSG;
                vars_q  <= chain_q;
                round_q <= '0;
                state_q <= ST_RUN;
              end else if (in_i.last) begin
                state_q <= ST_PAD;
              end
            end else if (in_i.last) begin
              state_q <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (pos >= LEN_POS) begin
            w_q     <= padded;
            phase_q <= PH_SPILL;
          end else begin
            w_q     <= {bit_len[31:0], bit_len[63:32], padded[13:0]};
            phase_q <= PH_FINAL;
          end
          vars_q  <= chain_q;
          round_q <= '0;
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          vars_q <= vars_d;
          w_q    <= {w_new, w_q[15:1]};
          round_q <= round_q + 6'd1;
          if (round_q == 6'd63) begin
            state_q <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          unique case (phase_q)
            PH_FINAL: begin
              // The digest waits here until the output register is free.
              if (!out_valid_q || out_o.ready) begin
                for (int i = 0; i < 8; i++) begin
                  digest_q[i] <= chain_q[i] + vars_q[i];
                end
                chain_q     <= IV;
                count_q     <= '0;
                pend_last_q <= 1'b0;
                state_q     <= ST_IDLE;
              end
            end
            PH_SPILL: begin
              for (int i = 0; i < 8; i++) begin
                chain_q[i] <= chain_q[i] + vars_q[i];
                vars_q[i]  <= chain_q[i] + vars_q[i];
              end
              for (int i = 0; i < 14; i++) begin
                w_q[i] <= '0;
              end
              w_q[14] <= bit_len[63:32];
              w_q[15] <= bit_len[31:0];
              phase_q <= PH_FINAL;
              round_q <= '0;
              state_q <= ST_RUN;
            end
            default: begin
              for (int i = 0; i < 8; i++) begin
                chain_q[i] <= chain_q[i] + vars_q[i];
              end
              state_q <= pend_last_q ? ST_PAD : ST_IDLE;
            end
          endcase
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.digest_word0 = digest_q[0];
  assign out_o.digest_word1 = digest_q[1];
  assign out_o.digest_word2 = digest_q[2];
  assign out_o.digest_word3 = digest_q[3];
  assign out_o.digest_word4 = digest_q[4];
  assign out_o.digest_word5 = digest_q[5];
  assign out_o.digest_word6 = digest_q[6];
  assign out_o.digest_word7 = digest_q[7];

  a_round_only_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (round_q != 6'd0) |-> (state_q == ST_RUN))
    else $error("round counter moved outside a compression");

  a_full_block_compresses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.byte_valid && pos == 6'd63) |=> (state_q == ST_RUN && round_q == 6'd0))
    else $error("completed block did not start a compression");

  a_digest_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (count_q == 61'd0 && state_q == ST_IDLE))
    else $error("digest issued without clearing the message state");

  a_last_goes_to_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.last && !in_i.byte_valid) |=> (state_q == ST_PAD))
    else $error("final word without a byte did not start padding");

endmodule

@@ tb/sv/sha256_message_hasher_checker.sv @@
// Checker that watches both channels of the hasher, predicts digests and compares them.
`timescale 1ns / 1ps
module sha256_message_hasher_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  shamh_in_if         in_mon,
  shamh_out_if        out_mon,
  output int          fail_count_o,
  output int          pending_digests_o
);
  import shamh_pkg::*;

  vars_t     chain;
  word_t     blk [16];
  bit [60:0] byte_count;
  vars_t     digest_queue [$];

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    word_t w [64];
    word_t a, b, c, d, e, f, g, h, t1, t2, x, y;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++) begin
      x = w[i-15];
      y = w[i-2];
      w[i] = w[i-16] + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + w[i-7]
             + (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10));
    end
    {h, g, f, e, d, c, b, a} = chain;
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + round_k(i[5:0]) + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endtask

  task automatic place(int p, logic [7:0] v);
    blk[p >> 2][(3 - (p & 3)) * 8 +: 8] = v;
  endtask

  task automatic absorb_word(logic [7:0] db, logic bv, logic lst);
    int p;
    bit [63:0] bits;
    if (bv) begin
      p = byte_count[5:0];
      place(p, db);
      byte_count = byte_count + 1;
      if (p == 63) compress();
    end
    if (lst) begin
      p = byte_count[5:0];
      place(p, PAD_BYTE);
      for (int q = p + 1; q < 64; q++) place(q, 8'h00);
      if (p >= LEN_POS) begin
        compress();
        for (int q = 0; q < 16; q++) blk[q] = '0;
      end
      bits = {byte_count, 3'b000};
      blk[14] = bits[63:32];
      blk[15] = bits[31:0];
      compress();
      digest_queue = {digest_queue, chain};
      chain = IV;
      byte_count = '0;
    end
  endtask

  assign pending_digests_o = digest_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    vars_t got, want;
    if (!rst_ni) begin
      chain = IV;
      byte_count = '0;
      for (int q = 0; q < 16; q++) blk[q] = '0;
      fail_count_o = 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        absorb_word(in_mon.data_byte, in_mon.byte_valid, in_mon.last);
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.digest_word7, out_mon.digest_word6, out_mon.digest_word5,
               out_mon.digest_word4, out_mon.digest_word3, out_mon.digest_word2,
               out_mon.digest_word1, out_mon.digest_word0};
        if (digest_queue.size() == 0) begin
          $display("%0t: unexpected digest %h", $time, got);
          fail_count_o++;
        end else begin
          want = digest_queue.pop_front();
          for (int i = 0; i < 8; i++)
            if (got[i] !== want[i]) begin
              $display("%0t: digest_word%0d expected %h actual %h", $time, i, want[i], got[i]);
              fail_count_o++;
            end
        end
      end
    end
  end
endmodule

@@ tb/sv/sha256_message_hasher_core_test.sv @@
// Top of the hasher testbench: clock, reset, byte stimulus, output stalls and verdict.
`timescale 1ns / 1ps
module sha256_message_hasher_core_test;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending_digests;
  int   cycle_count = 0;
  int   sent = 0;
  int   stall_left = 0;
  bit   calm = 1'b0;
  bit   long_hold = 1'b0;

  shamh_in_if  in_ch ();
  shamh_out_if out_ch ();

  sha256_message_hasher_core dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));
  sha256_message_hasher_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count_o(fail_count), .pending_digests_o(pending_digests)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.byte_valid = 1'b0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one word and hold it until accepted, with random idle bursts ahead of it.
  // Valid stays high between back-to-back words.
  task automatic send_word(logic [7:0] db, logic bv, logic lst);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= db;
    in_ch.byte_valid <= bv;
    in_ch.last <= lst;
    do @(posedge clk_i); while (!in_ch.ready);
    sent++;
  endtask

  task automatic send_message(int len, int pattern);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (pattern)
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = $urandom_range(0, 255);
      endcase
      if ($urandom_range(0, 9) == 0) send_word($urandom_range(0, 255), 1'b0, 1'b0);
      send_word(b, 1'b1, (i == len - 1) && pattern != 3);
    end
    // A message may also end on a final word with no byte.
    if (len == 0 || pattern == 3) send_word($urandom_range(0, 255), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_digests != 0) @(posedge clk_i);
  endtask

  // Receiver: random idle bursts, one long hold-off on request, none at the end.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (long_hold) begin
      out_ch.ready <= 1'b0;
    end else if (calm) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    int len;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: empty, single bytes at both extremes, padding boundaries.
    send_message(0, 2);
    send_message(1, 0);
    send_message(1, 1);
    send_message(55, 2);
    send_message(56, 1);
    send_message(64, 3);
    send_word(8'h5a, 1'b0, 1'b0);
    send_message(63, 0);
    // Sender pauses until every digest has come out.
    wait_drained();
    // Receiver holds off while short messages keep arriving.
    fork
      begin
        long_hold = 1'b1;
        repeat (600) @(posedge clk_i);
        long_hold = 1'b0;
      end
      begin
        for (int m = 0; m < 6; m++) send_message($urandom_range(0, 5), 2);
      end
    join
    while (sent < 1800) begin
      if (sent > 1500) calm = 1'b1;
      case ($urandom_range(0, 5))
        0: len = $urandom_range(0, 3);
        1: len = $urandom_range(54, 66);
        2: len = $urandom_range(118, 130);
        default: len = $urandom_range(0, 40);
      endcase
      send_message(len, $urandom_range(0, 7) == 0 ? 3 : 2);
    end
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending_digests == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
